// ===== rtl/sensor_window_stats_defines.svh =====
// Assertion macros used by the checker file of the sensor window statistics block.
`ifndef SENSOR_WINDOW_STATS_DEFINES_SVH
`define SENSOR_WINDOW_STATS_DEFINES_SVH

// Property that must hold on every rising clock edge outside reset.
`define SWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle that implies another condition in the next cycle.
`define SWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sws_pkg.sv =====
// Types, constants and controller/datapath links of the sensor window statistics block.
package sws_pkg;

  // Field widths.
  localparam int RAW_W  = 10;
  localparam int TEMP_W = 14;
  localparam int CNT_W  = 16;
  localparam int WIN_W  = 4;

  // Action codes of an input word.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Scaling raw*12000/1023 is done as (raw*SCALE_MULT) >> SCALE_SHIFT, with the
  // multiplier rounded up; the shift is wide enough that the floor is exact
  // for every 10-bit input.
  localparam int SCALE_SHIFT = 20;
  localparam int MULT_W      = 24;
  localparam longint unsigned SCALE_MULT_L =
    ((64'd12000 << SCALE_SHIFT) + 64'd1022) / 64'd1023;
  localparam logic [MULT_W-1:0] SCALE_MULT = MULT_W'(SCALE_MULT_L);

  // Statistic constants in hundredths of a degree.
  localparam logic [TEMP_W-1:0] FULL_SCALE_OUT = 14'd12000;
  localparam logic [TEMP_W-1:0] MIN_AT_RESET   = 14'd9999;
  localparam logic [TEMP_W-1:0] MIN_AT_CLEAR   = 14'd9900;
  localparam logic [CNT_W-1:0]  COUNT_MAX      = '1;

  // Window length limits.
  localparam logic [WIN_W-1:0] WIN_MIN   = 4'd1;
  localparam logic [WIN_W-1:0] WIN_MAX   = 4'd9;
  localparam logic [WIN_W-1:0] WIN_RESET = 4'd1;

  // Window sum and divider sizing: 9 * 12000 fits in 17 bits, the divider
  // retires two quotient bits per step over an 18-bit dividend.
  localparam int SUM_W     = 17;
  localparam int DIV_W     = 18;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int DIV_CNT_W = 4;

  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [CNT_W-1:0]  count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scale;
    logic update;
    logic read;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_last;
    logic div_last;
    logic out_free;
  } status_t;

  // One result word.
  typedef struct packed {
    temp_t  latest_temp;
    temp_t  window_average;
    temp_t  highest_seen;
    temp_t  lowest_seen;
    count_t sample_count;
    temp_t  oldest_stored;
    logic   led_on;
  } res_t;

endpackage

// ===== rtl/sws_if.sv =====
// Valid/ready channel interfaces for the input and result words.
interface sws_in_if import sws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [RAW_W-1:0]   raw_sample;

  modport source (output valid, action, raw_sample, input ready);
  modport sink   (input valid, action, raw_sample, output ready);
endinterface

interface sws_out_if import sws_pkg::*; ();
  logic   valid;
  logic   ready;
  temp_t  latest_temp;
  temp_t  window_average;
  temp_t  highest_seen;
  temp_t  lowest_seen;
  count_t sample_count;
  temp_t  oldest_stored;
  logic   led_on;

  modport source (output valid, latest_temp, window_average, highest_seen, lowest_seen,
                  sample_count, oldest_stored, led_on, input ready);
  modport sink   (input valid, latest_temp, window_average, highest_seen, lowest_seen,
                  sample_count, oldest_stored, led_on, output ready);
endinterface

// ===== rtl/sws_ctrl.sv =====
// Sequencing state machine of the sensor window statistics block.
module sws_ctrl import sws_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCALE  = 7'b0000010,
    S_UPDATE = 7'b0000100,
    S_READ   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_READ;
      end
      S_READ: begin
        // Window entries newest first, then the oldest entry.
        cmd_o.read = 1'b1;
        if (status_i.read_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/sws_datapath.sv =====
// Scaling, sample ring, running statistics, window sum and divider.
module sws_datapath import sws_pkg::*; #(
  parameter int RING_DEPTH = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i,
  input  logic             in_action_i,
  input  logic [RAW_W-1:0] in_raw_sample_i,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output res_t             out_res_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

  // One radix-2 restoring step: returns the quotient bit over the new remainder.
  function automatic logic [WIN_W:0] div_bit(input logic [WIN_W-1:0] rem,
                                             input logic             in_bit,
                                             input logic [WIN_W-1:0] den);
    logic [WIN_W:0] t;
    logic [WIN_W:0] diff;
    t    = {rem, in_bit};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {1'b1, diff[WIN_W-1:0]};
    end
    return {1'b0, t[WIN_W-1:0]};
  endfunction

  logic [WIN_W-1:0]  win_len_q;
  logic              action_q;
  logic [RAW_W-1:0]  raw_q;
  temp_t             scaled_q;
  logic [AW-1:0]     widx_q;
  logic              full_q;
  temp_t             max_q, min_q;
  count_t            count_q;
  temp_t             ring_mem [RING_DEPTH];
  logic [AW-1:0]     rd_ptr_q;
  logic [WIN_W-1:0]  rd_k_q;
  temp_t             rd_data_q;
  logic              rd_ok_q, rd_live_q, rd_first_q, rd_win_q, rd_old_q;
  logic [SUM_W-1:0]  sum_q;
  temp_t             latest_q, oldest_q;
  logic [DIV_W-1:0]  quo_q;
  logic [WIN_W-1:0]  rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic              out_valid_q;
  res_t              out_res_q;

  logic [WIN_W-1:0]  n_eff;
  logic [RAW_W+MULT_W-1:0] prod;
  logic [AW-1:0]     widx_inc, widx_next, ptr_init, ptr_dec, oldest_addr, rd_addr;
  logic              rd_is_old, rd_ok_d;
  temp_t             rd_val;
  logic [WIN_W:0]    step_a, step_b;

  // Window length clamped to 1..9.
  always_comb begin
    priority if (win_len_q == '0) begin
      n_eff = WIN_MIN;
    end else if (win_len_q > WIN_MAX) begin
      n_eff = WIN_MAX;
    end else begin
      n_eff = win_len_q;
    end
  end

  // Scaling product; the result is the upper slice.
  assign prod = raw_q * SCALE_MULT;

  // Ring pointers with wrap at the ring depth.
  assign widx_inc    = (widx_q == LAST_ADDR) ? '0 : widx_q + 1'b1;
  assign widx_next   = (action_q == ACT_SAMPLE) ? widx_inc : widx_q;
  assign ptr_init    = (widx_next == '0) ? LAST_ADDR : widx_next - 1'b1;
  assign ptr_dec     = (rd_ptr_q == '0) ? LAST_ADDR : rd_ptr_q - 1'b1;
  assign rd_is_old   = (rd_k_q == n_eff);
  assign oldest_addr = full_q ? widx_q : '0;
  assign rd_addr     = rd_is_old ? oldest_addr : rd_ptr_q;

  // An entry has been written once the ring wrapped or it lies below the write index.
  assign rd_ok_d = full_q || (rd_addr < widx_q);
  assign rd_val  = rd_ok_q ? rd_data_q : '0;

  // Two divider steps per cycle.
  assign step_a = div_bit(rem_q, quo_q[DIV_W-1], n_eff);
  assign step_b = div_bit(step_a[WIN_W-1:0], quo_q[DIV_W-2], n_eff);

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && (action_q == ACT_SAMPLE)) begin
      ring_mem[widx_q] <= scaled_q;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_action_i;
      raw_q    <= in_raw_sample_i;
    end
    if (cmd_i.scale) begin
      scaled_q <= prod[SCALE_SHIFT +: TEMP_W];
    end
    if (cmd_i.read) begin
      rd_ok_q    <= rd_ok_d;
      rd_first_q <= (rd_k_q == '0);
      rd_win_q   <= !rd_is_old;
      rd_old_q   <= rd_is_old;
    end
    if (cmd_i.load_out) begin
      out_res_q.latest_temp    <= latest_q;
      out_res_q.window_average <= quo_q[TEMP_W-1:0];
      out_res_q.highest_seen   <= max_q;
      out_res_q.lowest_seen    <= min_q;
      out_res_q.sample_count   <= count_q;
      out_res_q.oldest_stored  <= oldest_q;
      out_res_q.led_on         <= count_q[0];
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      win_len_q <= cfg_wdata_i;
    end
  end

  // Ring fill tracking and running statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q  <= '0;
      full_q  <= 1'b0;
      max_q   <= '0;
      min_q   <= MIN_AT_RESET;
      count_q <= '0;
    end else if (cmd_i.update) begin
      if (action_q == ACT_SAMPLE) begin
        widx_q <= widx_inc;
        if (widx_q == LAST_ADDR) begin
          full_q <= 1'b1;
        end
        if (scaled_q > max_q) begin
          max_q <= scaled_q;
        end
        if (scaled_q < min_q) begin
          min_q <= scaled_q;
        end
        if (count_q != COUNT_MAX) begin
          count_q <= count_q + 1'b1;
        end
      end else begin
        max_q <= '0;
        min_q <= MIN_AT_CLEAR;
      end
    end
  end

  // Window walk: issue reads, then accumulate the returned words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      rd_k_q    <= '0;
      rd_live_q <= 1'b0;
      sum_q     <= '0;
      latest_q  <= '0;
      oldest_q  <= '0;
    end else begin
      rd_live_q <= cmd_i.read;
      if (cmd_i.update) begin
        rd_ptr_q <= ptr_init;
        rd_k_q   <= '0;
        sum_q    <= '0;
      end else if (cmd_i.read) begin
        rd_ptr_q <= ptr_dec;
        rd_k_q   <= rd_k_q + 1'b1;
      end
      if (rd_live_q) begin
        if (rd_win_q) begin
          sum_q <= sum_q + SUM_W'(rd_val);
        end
        if (rd_first_q) begin
          latest_q <= rd_val;
        end
        if (rd_old_q) begin
          oldest_q <= rd_val;
        end
      end
    end
  end

  // Iterative divider for the window average.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q     <= '0;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      quo_q     <= DIV_W'(sum_q);
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q     <= {quo_q[DIV_W-3:0], step_a[WIN_W], step_b[WIN_W]};
      rem_q     <= step_b[WIN_W-1:0];
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Status to the controller.
  assign status_o.read_last = rd_is_old;
  assign status_o.div_last  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== rtl/sensor_window_stats.sv =====
// Each input word is scaled, updates the statistics, then runs the ring walk (one memory read
// per window entry plus one for the oldest entry, N = window length 1..9) and the 9-step divider;
// a new input word is taken only after the previous word has reached the result register.
// The result register frees the input side: a new word is taken while a result waits.
// Reset (asynchronous, active low) clears control, statistics and ring fill tracking;
// unwritten ring entries read as zero, so no clearing pass is needed.
module sensor_window_stats import sws_pkg::*; #(
  parameter int RING_DEPTH = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [WIN_W-1:0] cfg_wdata_i,
  sws_in_if.sink           in_i,
  sws_out_if.source        out_o
);

  cmd_t    cmd;
  status_t status;
  res_t    res;
  logic    out_valid;

  // Sequencer.
  sws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  sws_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_action_i     (in_i.action),
    .in_raw_sample_i (in_i.raw_sample),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_valid),
    .out_res_o       (res)
  );

  // Result channel.
  assign out_o.valid          = out_valid;
  assign out_o.latest_temp    = res.latest_temp;
  assign out_o.window_average = res.window_average;
  assign out_o.highest_seen   = res.highest_seen;
  assign out_o.lowest_seen    = res.lowest_seen;
  assign out_o.sample_count   = res.sample_count;
  assign out_o.oldest_stored  = res.oldest_stored;
  assign out_o.led_on         = res.led_on;

endmodule

// ===== rtl/sws_checker.sv =====
// Port-level assertions for the sensor window statistics block and their bind.
`include "sensor_window_stats_defines.svh"

module sws_checker import sws_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input temp_t  latest_i,
  input temp_t  average_i,
  input temp_t  highest_i,
  input temp_t  lowest_i,
  input count_t count_i,
  input temp_t  oldest_i,
  input logic   led_i
);

  // A stalled result word stays valid, and its latest value, average and count do not change.
  `SWS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(latest_i) && $stable(average_i) && $stable(count_i), "result word changed while stalled")

  // The LED flag follows the parity of the sample count.
  `SWS_ASSERT(a_led_parity, clk_i, rst_ni, out_valid_i |-> (led_i == count_i[0]), "LED flag does not match count parity")

  // Extremes and average stay within the scaled range.
  `SWS_ASSERT(a_stats_range, clk_i, rst_ni, out_valid_i |-> (highest_i <= FULL_SCALE_OUT && lowest_i <= MIN_AT_RESET && average_i <= FULL_SCALE_OUT), "statistic out of range")

  // With no sample taken, the ring and the maximum read as zero.
  `SWS_ASSERT(a_empty_zero, clk_i, rst_ni, (out_valid_i && count_i == '0) |-> (highest_i == '0 && latest_i == '0 && oldest_i == '0), "nonzero value before any sample")

endmodule

bind sensor_window_stats sws_checker u_sws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .latest_i    (out_o.latest_temp),
  .average_i   (out_o.window_average),
  .highest_i   (out_o.highest_seen),
  .lowest_i    (out_o.lowest_seen),
  .count_i     (out_o.sample_count),
  .oldest_i    (out_o.oldest_stored),
  .led_i       (out_o.led_on)
);
